// ===== src/hmmsf_pkg.sv =====
// Package with the opcodes and fixed widths of the scaled forward step.
package hmmsf_pkg;

   localparam int ProbWidth = 17;
   localparam logic [ProbWidth-1:0] ProbOne = 17'h10000;
   localparam int NumStates = 8;
   localparam int NumSymbols = 16;
   localparam int SumWidth = 24;

   typedef enum logic [1:0] {
      OP_LOAD_TRANS = 2'd0,
      OP_LOAD_EMIT  = 2'd1,
      OP_LOAD_INIT  = 2'd2,
      OP_OBSERVE    = 2'd3
   } op_type;

   function automatic logic [ProbWidth-1:0] sat_one(input logic [47:0] v);
      logic [ProbWidth-1:0] r;
      r = (v > 48'(ProbOne)) ? ProbOne : v[ProbWidth-1:0];
      return r;
   endfunction

endpackage

// ===== src/hmmsf_cell.sv =====
// One state's cell: holds its forward value and accumulates its transition sum.
module hmmsf_cell
   import hmmsf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 acc_clear,
   input  logic                 acc_en,
   input  logic [ProbWidth-1:0] trans_in,
   input  logic [ProbWidth-1:0] ring_in,
   input  logic                 ring_shift,
   input  logic                 load_en,
   input  logic [ProbWidth-1:0] load_value,
   output logic [ProbWidth-1:0] fwd_out,
   output logic [SumWidth-1:0]  sum_out
);

   logic [ProbWidth-1:0] fwd_ff, fwd_in;
   logic [39:0]          acc_ff, acc_in;
   logic [33:0]          prod;

   assign prod = fwd_ff * trans_in;

   always_comb begin
      fwd_in = fwd_ff;
      if (load_en) begin
         fwd_in = load_value;
      end else if (ring_shift) begin
         fwd_in = ring_in;
      end
      acc_in = acc_ff;
      if (acc_clear) begin
         acc_in = '0;
      end else if (acc_en) begin
         acc_in = acc_ff + 40'(prod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
      end else begin
         fwd_ff <= fwd_in;
      end
      acc_ff <= acc_in;
   end

   logic [39:0] rounded;
   assign rounded = acc_ff + 40'd32768;
   assign fwd_out = fwd_ff;
   assign sum_out = rounded[39:16];

endmodule

// ===== src/hmmsf_divider.sv =====
// Restoring divider for the normalization quotient, one bit per cycle.
module hmmsf_divider
   import hmmsf_pkg::*;
#(
   parameter int CoeffWidth = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ProbWidth-1:0]  numer,
   input  logic [CoeffWidth-1:0] denom,
   output logic                  done,
   output logic [ProbWidth-1:0]  quot
);

   localparam int NumW = ProbWidth + 16 + 1;
   localparam int QBits = ProbWidth + 1;
   localparam int CntW = $clog2(QBits + 1);

   logic [NumW-1:0]       num_ff, num_in;
   logic [CoeffWidth:0]   rem_ff, rem_in;
   logic [QBits-1:0]      q_ff, q_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [CoeffWidth:0]   trial;
   logic [NumW-1:0]       dividend;

   assign dividend = {1'b0, numer, 16'd0} + NumW'(denom >> 1);

   // Quotient bits above the 18th are dropped since u <= c keeps it at most 65536.
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[CoeffWidth-1:0], num_ff[NumW-1]};
      if (start) begin
         num_in  = dividend << (NumW - QBits);
         rem_in  = (CoeffWidth+1)'(dividend >> QBits);
         q_in    = '0;
         cnt_in  = CntW'(QBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, denom}) begin
            rem_in = trial - {1'b0, denom};
            q_in   = {q_ff[QBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[QBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = busy_ff && cnt_ff == CntW'(1);
   assign quot = sat_one(48'(q_in));

endmodule

// ===== src/hmm_scaled_forward_step.sv =====
// Top level of the scaled HMM forward step with its chain of state cells.
//
// Channel  Direction  Ports
// req      in         req_valid, req_stall, req_op, req_row_index, req_col_index,
//                     req_prob_value, req_symbol, req_seq_start
// rsp      out        rsp_valid, rsp_stall, rsp_state_id, rsp_fwd_prob,
//                     rsp_scale_coeff, rsp_zero_sum, rsp_last_of_run
//
// A load word writes its table entry. An observation word runs through the
// accumulate ring (skipped at a sequence start) and the emission pass. Each state
// then goes through the shared divider (skipped on a zero sum) and presents its
// result, which leaves when rsp_stall is low; a final step reloads the cells.
// Reset is synchronous and clears the forward values of all cells.
// A stalled result holds the block; no new word is taken until all results leave.
module hmm_scaled_forward_step
   import hmmsf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [3:0]           req_row_index,
   input  logic [2:0]           req_col_index,
   input  logic [ProbWidth-1:0] req_prob_value,
   input  logic [3:0]           req_symbol,
   input  logic                 req_seq_start,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_state_id,
   output logic [ProbWidth-1:0] rsp_fwd_prob,
   output logic [ProbWidth-1:0] rsp_scale_coeff,
   output logic                 rsp_zero_sum,
   output logic                 rsp_last_of_run
);

   localparam int SW  = (NumStates > 1) ? $clog2(NumStates) : 1;
   localparam int YW  = (NumSymbols > 1) ? $clog2(NumSymbols) : 1;
   localparam int CW  = ProbWidth + SW;
   localparam int CtW = SW + 1;
   localparam int EW  = SumWidth + ProbWidth;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ACC   = 6'b000010,
      ST_EMIT  = 6'b000100,
      ST_EMUL  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   logic [ProbWidth-1:0] trans_mem [NumStates*NumStates];
   logic [ProbWidth-1:0] emit_mem [NumSymbols*NumStates];
   logic [ProbWidth-1:0] init_mem [NumStates];
   logic [ProbWidth-1:0] unorm_ff [NumStates];

   state_type            state_ff, state_in;
   logic [CtW-1:0]       j_ff, j_in;
   logic [CtW-1:0]       i_ff, i_in;
   logic                 start_ff;
   logic [3:0]           sym_ff;
   logic [CW-1:0]        coeff_ff;
   logic [ProbWidth-1:0] fwd_out_ff, new_fwd_ff [NumStates];
   logic                 rsp_valid_ff;
   logic                 div_start, div_done;
   logic [ProbWidth-1:0] div_quot;
   logic [ProbWidth-1:0] val_sat, trans_rd_ff, emit_rd_ff, init_rd_ff;
   logic [EW-1:0]        emul_prod;
   logic [ProbWidth-1:0] emul_p;
   logic [ProbWidth-1:0] cell_fwd [NumStates];
   logic [SumWidth-1:0]  cell_sum [NumStates];
   logic                 accept, sym_ok;

   assign accept  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign val_sat = sat_one(48'(req_prob_value));
   assign sym_ok  = 32'(sym_ff) < NumSymbols;

   always_ff @(posedge clock) begin
      if (accept) begin
         unique case (op_type'(req_op))
            OP_LOAD_TRANS: if (32'(req_row_index) < NumStates
                               && 32'(req_col_index) < NumStates) begin
               trans_mem[{req_row_index[SW-1:0], req_col_index[SW-1:0]}] <= val_sat;
            end
            OP_LOAD_EMIT: if (32'(req_row_index) < NumSymbols
                              && 32'(req_col_index) < NumStates) begin
               emit_mem[{req_row_index[YW-1:0], req_col_index[SW-1:0]}] <= val_sat;
            end
            OP_LOAD_INIT: if (32'(req_row_index) < NumStates) begin
               init_mem[req_row_index[SW-1:0]] <= val_sat;
            end
            OP_OBSERVE: begin
            end
            default: begin
            end
         endcase
      end
      trans_rd_ff <= trans_mem[{i_ff[SW-1:0], SW'(j_ff[SW-1:0] + i_ff[SW-1:0])}];
      emit_rd_ff  <= emit_mem[{sym_ff[YW-1:0], i_ff[SW-1:0]}];
      init_rd_ff  <= init_mem[i_ff[SW-1:0]];
   end

   // The accumulation rotates the forward ring; cell k sees source (k+j) mod N.
   // Transition reads are issued per cell in sequence, so the ring shifts by one
   // source only after every cell has accumulated the current one.
   logic [CtW-1:0] k_ff, k_in;

   genvar g;
   generate
      for (g = 0; g < NumStates; g++) begin : g_cell
         hmmsf_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .acc_clear  (accept),
            .acc_en     (state_ff == ST_ACC && k_ff == CtW'(g+1) && j_ff != CtW'(NumStates)),
            .trans_in   (trans_rd_ff),
            .ring_in    (cell_fwd[(g+1) % NumStates]),
            .ring_shift (state_ff == ST_ACC && k_ff == CtW'(NumStates+1)),
            .load_en    (state_ff == ST_OUT && !rsp_valid_ff && i_ff == CtW'(NumStates)),
            .load_value (new_fwd_ff[g]),
            .fwd_out    (cell_fwd[g]),
            .sum_out    (cell_sum[g])
         );
      end
   endgenerate

   assign emul_prod = (start_ff ? SumWidth'(init_rd_ff) : cell_sum[i_ff[SW-1:0]])
                      * (sym_ok ? emit_rd_ff : '0);
   assign emul_p = sat_one(48'((emul_prod + EW'(32768)) >> 16));

   hmmsf_divider #(.CoeffWidth(CW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (unorm_ff[i_ff[SW-1:0]]),
      .denom (coeff_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign div_start = state_ff == ST_DIV && j_ff == '0;

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && op_type'(req_op) == OP_OBSERVE) begin
            state_in = req_seq_start ? ST_EMIT : ST_ACC;
            i_in = '0; j_in = '0; k_in = '0;
         end
         ST_ACC: begin
            // k walks the cells: 0 issues read for cell 0, k=g+1 accumulates cell g.
            if (k_ff == CtW'(NumStates + 1)) begin
               k_in = '0; i_in = '0;
               if (j_ff == CtW'(NumStates - 1)) begin
                  state_in = ST_EMIT;
                  j_in = '0;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
               i_in = (k_ff < CtW'(NumStates - 1)) ? k_ff + 1'b1 : i_ff;
            end
         end
         ST_EMIT: begin
            state_in = ST_EMUL;
         end
         ST_EMUL: begin
            if (i_ff == CtW'(NumStates - 1)) begin
               state_in = ST_DIV; i_in = '0; j_in = '0;
            end else begin
               state_in = ST_EMIT; i_in = i_ff + 1'b1;
            end
         end
         ST_DIV: begin
            j_in = CtW'(1);
            if (coeff_ff == '0 || div_done) begin
               state_in = ST_OUT; j_in = '0;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               if (i_ff == CtW'(NumStates)) begin
                  state_in = ST_IDLE;
               end
            end else if (!rsp_stall) begin
               i_in = i_ff + 1'b1;
               state_in = (i_ff == CtW'(NumStates - 1)) ? ST_OUT : ST_DIV;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff <= '0; j_ff <= '0; k_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
         if (state_ff == ST_DIV && (coeff_ff == '0 || div_done)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         start_ff <= req_seq_start;
         sym_ff   <= req_symbol;
         coeff_ff <= '0;
      end else if (state_ff == ST_EMUL) begin
         unorm_ff[i_ff[SW-1:0]] <= emul_p;
         coeff_ff <= coeff_ff + CW'(emul_p);
      end
      if (state_ff == ST_DIV && (coeff_ff == '0 || div_done)) begin
         fwd_out_ff <= (coeff_ff == '0) ? '0 : div_quot;
         new_fwd_ff[i_ff[SW-1:0]] <= (coeff_ff == '0) ? '0 : div_quot;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_state_id    = 3'(i_ff[SW-1:0]);
   assign rsp_fwd_prob    = fwd_out_ff;
   assign rsp_scale_coeff = sat_one(48'(coeff_ff));
   assign rsp_zero_sum    = coeff_ff == '0;
   assign rsp_last_of_run = i_ff == CtW'(NumStates - 1);

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("result word pending while idle");
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_sum) |-> rsp_fwd_prob == '0) else $error("zero sum gives nonzero");
   a_fwd_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fwd_prob <= ProbOne) else $error("forward value above one");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the scaled HMM forward step: loads, observations and random traffic.
module testbench;
   import hmmsf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomWords  = 20;
   localparam int WatchdogMax  = 5000;
   localparam int NumLoadedSymbols = 2;
   localparam logic [3:0] SilentSymbol = 4'd15;

   typedef struct packed {
      op_type               op;
      logic [3:0]           row;
      logic [2:0]           col;
      logic [ProbWidth-1:0] prob;
      logic [3:0]           sym;
      logic                 start;
      logic                 zero_known;
   } stim_word_type;

   typedef struct packed {
      logic [2:0]           state_id;
      logic [ProbWidth-1:0] fwd_prob;
      logic [ProbWidth-1:0] scale_coeff;
      logic                 zero_sum;
      logic                 last_of_run;
   } fwd_result_type;

   localparam int NumDirected = 16;
   localparam stim_word_type Directed[NumDirected] = '{
      '{OP_OBSERVE,    4'd0,  3'd0, 17'd0,       4'd0,  1'b0, 1'b1},
      '{OP_OBSERVE,    4'd15, 3'd0, 17'd0,       SilentSymbol, 1'b1, 1'b1},
      '{OP_LOAD_INIT,  4'd0,  3'd0, 17'h1ffff,   4'd0,  1'b0, 1'b0},
      '{OP_LOAD_EMIT,  4'd1,  3'd0, 17'h10000,   4'd0,  1'b0, 1'b0},
      '{OP_LOAD_EMIT,  4'd1,  3'd7, 17'h1ffff,   4'd0,  1'b0, 1'b0},
      '{OP_LOAD_TRANS, 4'd9,  3'd0, 17'd5,       4'd0,  1'b0, 1'b0},
      '{OP_LOAD_INIT,  4'd12, 3'd5, 17'h0ffff,   4'd0,  1'b0, 1'b0},
      '{OP_OBSERVE,    4'd0,  3'd0, 17'd0,       4'd1,  1'b1, 1'b0},
      '{OP_OBSERVE,    4'd0,  3'd0, 17'd0,       4'd1,  1'b0, 1'b0},
      '{OP_LOAD_TRANS, 4'd7,  3'd7, 17'd0,       4'd0,  1'b0, 1'b0},
      '{OP_LOAD_TRANS, 4'd0,  3'd0, 17'h1ffff,   4'd0,  1'b0, 1'b0},
      '{OP_OBSERVE,    4'd0,  3'd0, 17'd0,       4'd0,  1'b0, 1'b0},
      '{OP_OBSERVE,    4'd0,  3'd0, 17'd0,       SilentSymbol, 1'b0, 1'b1},
      '{OP_OBSERVE,    4'd0,  3'd0, 17'd0,       4'd0,  1'b0, 1'b1},
      '{OP_OBSERVE,    4'd0,  3'd0, 17'd0,       4'd1,  1'b1, 1'b0},
      '{OP_OBSERVE,    4'd0,  3'd0, 17'd0,       4'd0,  1'b0, 1'b0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_op;
   logic [3:0]           req_row_index;
   logic [2:0]           req_col_index;
   logic [ProbWidth-1:0] req_prob_value;
   logic [3:0]           req_symbol;
   logic                 req_seq_start;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [2:0]           rsp_state_id;
   logic [ProbWidth-1:0] rsp_fwd_prob;
   logic [ProbWidth-1:0] rsp_scale_coeff;
   logic                 rsp_zero_sum;
   logic                 rsp_last_of_run;

   logic [ProbWidth-1:0] trans_tab[NumStates*NumStates];
   logic [ProbWidth-1:0] emit_tab[NumSymbols*NumStates];
   logic [ProbWidth-1:0] init_tab[NumStates];
   logic [ProbWidth-1:0] alpha_prev[NumStates];
   fwd_result_type       pending_results[$];
   int                   error_count = 0;
   int                   idle_cycles;
   int                   stall_left;

   hmm_scaled_forward_step u_dut (.*);

   always #5 clock = ~clock;

   function automatic logic [ProbWidth-1:0] clamp_one(input logic [63:0] v);
      return (v > 64'(ProbOne)) ? ProbOne : v[ProbWidth-1:0];
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Observations only use symbols whose emission rows were written.
   function automatic logic [3:0] pick_symbol();
      int r;
      r = $urandom_range(0, NumLoadedSymbols);
      if (r == NumLoadedSymbols) return SilentSymbol;
      return 4'(r);
   endfunction

   // Applies one accepted word to the local tables and queues its expected results.
   function automatic void apply_word(input stim_word_type w);
      logic [63:0]          unnorm[NumStates];
      logic [63:0]          total;
      logic [63:0]          acc;
      logic [63:0]          rounded;
      logic [63:0]          emis;
      logic [63:0]          prod;
      logic [ProbWidth-1:0] val;
      fwd_result_type       res;
      val = clamp_one(64'(w.prob));
      case (w.op)
         OP_LOAD_TRANS: if (w.row < NumStates) trans_tab[w.row*NumStates + w.col] = val;
         OP_LOAD_EMIT:  if (w.row < NumSymbols) emit_tab[w.row*NumStates + w.col] = val;
         OP_LOAD_INIT:  if (w.row < NumStates) init_tab[w.row] = val;
         default: begin
            total = 0;
            for (int i = 0; i < NumStates; i++) begin
               emis = (w.sym < NumSymbols) ? 64'(emit_tab[w.sym*NumStates + i]) : 64'd0;
               if (w.start) begin
                  prod = (64'(init_tab[i]) * emis + 64'd32768) >> 16;
               end else begin
                  acc = 0;
                  for (int j = 0; j < NumStates; j++)
                     acc += 64'(alpha_prev[j]) * 64'(trans_tab[i*NumStates + j]);
                  rounded = (acc + 64'd32768) >> 16;
                  prod = (rounded * emis + 64'd32768) >> 16;
               end
               unnorm[i] = 64'(clamp_one(prod));
               total += unnorm[i];
            end
            for (int i = 0; i < NumStates; i++) begin
               res.state_id = 3'(i);
               res.fwd_prob = (total != 0) ?
                  clamp_one((unnorm[i] * 64'(ProbOne) + total / 2) / total) : '0;
               res.scale_coeff = clamp_one(total);
               res.zero_sum = (total == 0);
               res.last_of_run = (i == NumStates - 1);
               alpha_prev[i] = res.fwd_prob;
               if (w.zero_known) begin
                  res.fwd_prob = '0;
                  res.scale_coeff = '0;
                  res.zero_sum = 1'b1;
               end
               pending_results.push_back(res);
            end
         end
      endcase
   endfunction

   task automatic send_word(input stim_word_type w);
      int gap;
      req_valid <= 1'b1;
      req_op <= w.op;
      req_row_index <= w.row;
      req_col_index <= w.col;
      req_prob_value <= w.prob;
      req_symbol <= w.sym;
      req_seq_start <= w.start;
      do @(posedge clock); while (req_stall);
      apply_word(w);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [ProbWidth-1:0] random_prob();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return ProbOne;
      if (r == 1) return 17'($urandom);
      if (r == 2) return 17'($urandom_range(0, 15));
      return 17'($urandom_range(0, 65536));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time,
                        {rsp_state_id, rsp_fwd_prob, rsp_scale_coeff, rsp_zero_sum,
                         rsp_last_of_run});
               error_count++;
            end else begin
               fwd_result_type e;
               e = pending_results.pop_front();
               if (rsp_state_id !== e.state_id) begin
                  $display("%0t: state_id expected %0d actual %0d", $time,
                           e.state_id, rsp_state_id);
                  error_count++;
               end
               if (rsp_fwd_prob !== e.fwd_prob) begin
                  $display("%0t: fwd_prob expected %0d actual %0d", $time,
                           e.fwd_prob, rsp_fwd_prob);
                  error_count++;
               end
               if (rsp_scale_coeff !== e.scale_coeff) begin
                  $display("%0t: scale_coeff expected %0d actual %0d", $time,
                           e.scale_coeff, rsp_scale_coeff);
                  error_count++;
               end
               if (rsp_zero_sum !== e.zero_sum) begin
                  $display("%0t: zero_sum expected %0d actual %0d", $time,
                           e.zero_sum, rsp_zero_sum);
                  error_count++;
               end
               if (rsp_last_of_run !== e.last_of_run) begin
                  $display("%0t: last_of_run expected %0d actual %0d", $time,
                           e.last_of_run, rsp_last_of_run);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            stall_left <= pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogMax) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      stim_word_type w;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_LOAD_TRANS;
      req_row_index = '0;
      req_col_index = '0;
      req_prob_value = '0;
      req_symbol = '0;
      req_seq_start = 1'b0;
      for (int i = 0; i < NumStates; i++) alpha_prev[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Every table entry that an observation reads is written before that observation.
      // Only the first emission rows and the last symbol's row are written, and
      // the last symbol is given zero emission everywhere.
      w = '0;
      for (int i = 0; i < NumStates*NumStates; i++) begin
         w.op = OP_LOAD_TRANS;
         w.row = 4'(i / NumStates);
         w.col = 3'(i % NumStates);
         w.prob = random_prob();
         send_word(w);
      end
      for (int i = 0; i < (NumLoadedSymbols + 1)*NumStates; i++) begin
         w.op = OP_LOAD_EMIT;
         w.row = (i / NumStates == NumLoadedSymbols) ? SilentSymbol : 4'(i / NumStates);
         w.col = 3'(i % NumStates);
         w.prob = (w.row == SilentSymbol) ? '0 : random_prob();
         send_word(w);
      end
      for (int i = 0; i < NumStates; i++) begin
         w.op = OP_LOAD_INIT;
         w.row = 4'(i);
         w.col = 3'($urandom);
         w.prob = random_prob();
         send_word(w);
      end

      foreach (Directed[k]) send_word(Directed[k]);

      for (int n = 0; n < RandomWords; n++) begin
         int pick;
         w = '0;
         w.col = 3'($urandom);
         w.prob = random_prob();
         w.sym = pick_symbol();
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            w.op = OP_OBSERVE;
            w.row = 4'($urandom);
            w.start = ($urandom_range(0, 4) == 0);
         end else begin
            w.op = op_type'($urandom_range(0, 2));
            w.row = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15)) :
                    (w.op == OP_LOAD_EMIT) ? 4'($urandom) : 4'($urandom_range(0, 7));
         end
         send_word(w);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/hmmsf_pkg.sv
src/hmmsf_cell.sv
src/hmmsf_divider.sv
src/hmm_scaled_forward_step.sv
test/testbench.sv
